// ===== src/spq_pkg.sv =====
// Package with the shared constants, codes and control types of the sorted priority queue.
package spq_pkg;

  localparam int Depth = 16;
  localparam int CntW = $clog2(Depth + 1);
  localparam int DataW = 32;
  localparam int StatusW = 2;
  localparam int OccW = 5;

  localparam logic ActInsert = 1'b0;
  localparam logic ActRemove = 1'b1;

  localparam logic [StatusW-1:0] StInserted = 2'd0;
  localparam logic [StatusW-1:0] StRemoved = 2'd1;
  localparam logic [StatusW-1:0] StUnderflow = 2'd2;
  localparam logic [StatusW-1:0] StOverflow = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE
  } spq_op_e;

  typedef struct packed {
    logic load;
    spq_op_e op;
    logic [StatusW-1:0] code;
  } spq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } spq_stat_t;

endpackage

// ===== src/spq_if.sv =====
// Handshake interfaces for the request and result channels of the sorted priority queue.
interface spq_in_if;
  logic valid;
  logic ready;
  logic action;
  logic signed [spq_pkg::DataW-1:0] item_value;
  logic signed [spq_pkg::DataW-1:0] item_priority;

  modport source(output valid, action, item_value, item_priority, input ready);
  modport sink(input valid, action, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
  logic valid;
  logic ready;
  logic [spq_pkg::StatusW-1:0] status;
  logic signed [spq_pkg::DataW-1:0] out_value;
  logic signed [spq_pkg::DataW-1:0] out_priority;
  logic [spq_pkg::OccW-1:0] occupancy;

  modport source(output valid, status, out_value, out_priority, occupancy, input ready);
  modport sink(input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

// ===== src/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller and cell-row datapath.
// The result of a transfer is registered and presented in the cycle after it is accepted.
// Throughput: one item per cycle while results are taken; a row of compare-and-shift
// cells inserts or removes an entry.
// Reset: the asynchronous low reset empties the queue and drops any pending result.
module sorted_priority_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  spq_pkg::spq_cmd_t cmd;
  spq_pkg::spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .item_value_i    (in_i.item_value),
    .item_priority_i (in_i.item_priority),
    .status_o        (out_o.status),
    .out_value_o     (out_o.out_value),
    .out_priority_o  (out_o.out_priority),
    .occupancy_o     (out_o.occupancy)
  );

endmodule

// ===== src/spq_ctrl.sv =====
// Controller state machine that accepts requests and holds results until they are taken.
module spq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  spq_pkg::spq_stat_t  stat_i,
  output spq_pkg::spq_cmd_t   cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StHold = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == StIdle) || out_ready_i;
  assign out_valid_o = (state_q == StHold);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load = accept;
    cmd_o.op = spq_pkg::OP_NONE;
    cmd_o.code = spq_pkg::StInserted;
    if (in_action_i == spq_pkg::ActInsert) begin
      if (stat_i.full) begin
        cmd_o.code = spq_pkg::StOverflow;
      end else begin
        cmd_o.op = accept ? spq_pkg::OP_INSERT : spq_pkg::OP_NONE;
        cmd_o.code = spq_pkg::StInserted;
      end
    end else begin
      if (stat_i.empty) begin
        cmd_o.code = spq_pkg::StUnderflow;
      end else begin
        cmd_o.op = accept ? spq_pkg::OP_REMOVE : spq_pkg::OP_NONE;
        cmd_o.code = spq_pkg::StRemoved;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = StHold;
    end else if (out_ready_i) begin
      state_d = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/spq_datapath.sv =====
// Datapath with a sorted row of compare-and-shift cells and the result register.
module spq_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  spq_pkg::spq_cmd_t                     cmd_i,
  output spq_pkg::spq_stat_t                    stat_o,
  input  logic signed [spq_pkg::DataW-1:0]      item_value_i,
  input  logic signed [spq_pkg::DataW-1:0]      item_priority_i,
  output logic [spq_pkg::StatusW-1:0]           status_o,
  output logic signed [spq_pkg::DataW-1:0]      out_value_o,
  output logic signed [spq_pkg::DataW-1:0]      out_priority_o,
  output logic [spq_pkg::OccW-1:0]              occupancy_o
);

  logic signed [spq_pkg::DataW-1:0] val_q [spq_pkg::Depth];
  logic signed [spq_pkg::DataW-1:0] pri_q [spq_pkg::Depth];
  logic signed [spq_pkg::DataW-1:0] val_d [spq_pkg::Depth];
  logic signed [spq_pkg::DataW-1:0] pri_d [spq_pkg::Depth];
  logic [spq_pkg::Depth-1:0] stay;
  logic [spq_pkg::CntW-1:0] count_q, count_d;
  logic [spq_pkg::CntW+spq_pkg::OccW-1:0] count_ext;

  logic [spq_pkg::StatusW-1:0] status_q;
  logic signed [spq_pkg::DataW-1:0] out_value_q, out_priority_q;
  logic [spq_pkg::OccW-1:0] occupancy_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full = (count_q == spq_pkg::CntW'(spq_pkg::Depth));

  // A cell keeps its entry when it is occupied and not ranked behind the new one.
  always_comb begin
    for (int k = 0; k < spq_pkg::Depth; k++) begin
      stay[k] = (spq_pkg::CntW'(k) < count_q) && (pri_q[k] <= item_priority_i);
    end
  end

  always_comb begin
    for (int k = 0; k < spq_pkg::Depth; k++) begin
      val_d[k] = val_q[k];
      pri_d[k] = pri_q[k];
    end
    count_d = count_q;
    unique case (cmd_i.op)
      spq_pkg::OP_INSERT: begin
        count_d = count_q + 1'b1;
        for (int k = 0; k < spq_pkg::Depth; k++) begin
          if (!stay[k]) begin
            if (k == 0) begin
              val_d[k] = item_value_i;
              pri_d[k] = item_priority_i;
            end else if (stay[k-1]) begin
              val_d[k] = item_value_i;
              pri_d[k] = item_priority_i;
            end else begin
              val_d[k] = val_q[k-1];
              pri_d[k] = pri_q[k-1];
            end
          end
        end
      end
      spq_pkg::OP_REMOVE: begin
        count_d = count_q - 1'b1;
        for (int k = 0; k < spq_pkg::Depth - 1; k++) begin
          val_d[k] = val_q[k+1];
          pri_d[k] = pri_q[k+1];
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign count_ext = {{spq_pkg::OccW{1'b0}}, count_d};

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < spq_pkg::Depth; k++) begin
      val_q[k] <= val_d[k];
      pri_q[k] <= pri_d[k];
    end
    if (cmd_i.load) begin
      status_q <= cmd_i.code;
      occupancy_q <= count_ext[spq_pkg::OccW-1:0];
      if (cmd_i.op == spq_pkg::OP_REMOVE) begin
        out_value_q <= val_q[0];
        out_priority_q <= pri_q[0];
      end else begin
        out_value_q <= '0;
        out_priority_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign status_o = status_q;
  assign out_value_o = out_value_q;
  assign out_priority_o = out_priority_q;
  assign occupancy_o = occupancy_q;

endmodule
